@@ src/sync_pattern_window_search_assert.svh @@
// Assertion macros used by the sync pattern window search RTL.
`ifndef SYNC_PATTERN_WINDOW_SEARCH_ASSERT_SVH
`define SYNC_PATTERN_WINDOW_SEARCH_ASSERT_SVH

// Consequent must hold in the cycle after the antecedent.
`define SPWS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

// Expression must never be true.
`define SPWS_ASSERT_NEVER(label, clk, rst_n, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("assertion failed");

`endif

@@ src/spws_pkg.sv @@
// Package with constants, types and the sync pattern for the window search.
`default_nettype none
package spws_pkg;

  localparam int unsigned SYNC_LEN     = 32;
  localparam int unsigned MAX_BUF_DEF  = 1024;
  localparam int unsigned CNT_W        = 6;
  localparam int unsigned CONF_W       = 7;
  localparam int unsigned PAY_W        = 11;
  localparam int unsigned QDEPTH       = 4;
  localparam int unsigned QIDX_W       = 2;
  localparam int unsigned QCNT_W       = 3;
  localparam logic [7:0]  CONF_RESET   = 8'd75;
  localparam logic [7:0]  PAT_LO_BASE  = 8'hA0;
  localparam logic [7:0]  PAT_HI_BASE  = 8'h50;
  localparam int unsigned PAT_HALF     = 16;

  // Per-byte control handed from the input stage to the best tracker.
  typedef struct packed {
    logic valid;
    logic eval;
    logic first;
    logic last;
    logic have;
  } spws_ctl_t;

  // One finished result as it sits in the output queue.
  typedef struct packed {
    logic             found;
    logic [PAY_W-1:0] payload;
    logic [CNT_W-1:0] cnt;
  } spws_res_t;

  // Expected sync byte at window slot j: A0..AF then 50..5F.
  function automatic logic [7:0] pattern_at(input int unsigned j);
    logic [7:0] p;
    if (j < PAT_HALF) begin
      p = PAT_LO_BASE + 8'(j);
    end else begin
      p = PAT_HI_BASE + 8'(j - PAT_HALF);
    end
    return p;
  endfunction

endpackage
`default_nettype wire

@@ src/spws_cell.sv @@
// One window slot: holds a byte and whether it matches this slot's sync byte.
`default_nettype none
module spws_cell #(
  parameter logic [7:0] PAT = 8'h00
) (
  input  wire logic       clk,
  input  wire logic       shift_en,
  input  wire logic [7:0] byte_in,
  output logic      [7:0] byte_out,
  output logic            match_out
);

  logic [7:0] byte_r;
  logic       match_r;

  always_ff @(posedge clk) begin
    if (shift_en) begin
      byte_r  <= byte_in;
      match_r <= (byte_in == PAT);
    end
  end

  assign byte_out  = byte_r;
  assign match_out = match_r;

endmodule
`default_nettype wire

@@ src/spws_best.sv @@
// Match counter and earliest-best window tracker, one window per cycle.
`default_nettype none
module spws_best #(
  parameter int unsigned POS_W = 11
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic [spws_pkg::SYNC_LEN-1:0]       match,
  input  wire spws_pkg::spws_ctl_t                 ctl,
  input  wire logic [POS_W-1:0]                    start,
  output logic                                     res_valid,
  output logic                                     res_have,
  output logic      [spws_pkg::CNT_W-1:0]          res_cnt,
  output logic      [POS_W-1:0]                    res_start
);
  import spws_pkg::*;

  logic [CNT_W-1:0] count;
  logic             upd;
  logic [CNT_W-1:0] new_cnt;
  logic [POS_W-1:0] new_start;

  logic [CNT_W-1:0] best_cnt_r, best_cnt_nxt;
  logic [POS_W-1:0] best_start_r, best_start_nxt;
  logic             res_valid_r;
  logic             res_have_r;
  logic [CNT_W-1:0] res_cnt_r;
  logic [POS_W-1:0] res_start_r;

  always_comb begin
    count     = CNT_W'($countones(match));
    upd       = ctl.valid && ctl.eval && (ctl.first || (count > best_cnt_r));
    new_cnt   = upd ? count : best_cnt_r;
    new_start = upd ? start : best_start_r;
    best_cnt_nxt   = best_cnt_r;
    best_start_nxt = best_start_r;
    if (ctl.valid) begin
      // A finished buffer starts the next one from the reset values.
      best_cnt_nxt   = ctl.last ? '0 : new_cnt;
      best_start_nxt = ctl.last ? '0 : new_start;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      best_cnt_r   <= '0;
      best_start_r <= '0;
      res_valid_r  <= 1'b0;
    end else begin
      best_cnt_r   <= best_cnt_nxt;
      best_start_r <= best_start_nxt;
      res_valid_r  <= ctl.valid && ctl.last;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.valid && ctl.last) begin
      res_have_r  <= ctl.have;
      res_cnt_r   <= new_cnt;
      res_start_r <= new_start;
    end
  end

  assign res_valid = res_valid_r;
  assign res_have  = res_have_r;
  assign res_cnt   = res_cnt_r;
  assign res_start = res_start_r;

endmodule
`default_nettype wire

@@ src/spws_outq.sv @@
// Small result queue that parts the search pipeline from the output channel.
`default_nettype none
module spws_outq (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          wr_en,
  input  wire spws_pkg::spws_res_t           wr_data,
  input  wire logic                          rd_en,
  output spws_pkg::spws_res_t                rd_data,
  output logic                               not_empty,
  output logic [spws_pkg::QCNT_W-1:0]        fill
);
  import spws_pkg::*;

  spws_res_t         mem_r [QDEPTH];
  logic [QIDX_W-1:0] head_r, head_nxt;
  logic [QIDX_W-1:0] tail_r, tail_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;

  always_comb begin
    head_nxt = rd_en ? head_r + 1'b1 : head_r;
    tail_nxt = wr_en ? tail_r + 1'b1 : tail_r;
    cnt_nxt  = cnt_r + QCNT_W'(wr_en) - QCNT_W'(rd_en);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      tail_r <= '0;
      cnt_r  <= '0;
    end else begin
      head_r <= head_nxt;
      tail_r <= tail_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[tail_r] <= wr_data;
    end
  end

  assign rd_data   = mem_r[head_r];
  assign not_empty = (cnt_r != '0);
  assign fill      = cnt_r;

endmodule
`default_nettype wire

@@ src/sync_pattern_window_search.sv @@
// Top level of the sync pattern window search: cell chain, tracker and output queue.
//
// The block takes one byte per cycle and slides it through a row of 32 cells, each
// holding one window byte and a registered flag telling whether that byte equals the
// sync byte for its slot (A0..AF for the first sixteen slots, 50..5F for the rest).
// In the cycle after a byte enters, the 32 flags are counted and the earliest window
// with the strictly highest count is kept. A byte marked with in_tlast closes the
// buffer: one request leaves through the control, result and queue registers,
// carrying found in out_tuser and the payload index and best count in out_tdata.
// Found is set when count*100 >= confidence*32; the payload index is the best window
// start plus 32, or 0 when not found. Buffers shorter than 32 bytes report not found
// with count 0. The byte position stops at MAX_BUFFER and later bytes form no
// windows, though a last mark on them still closes the buffer. Throughput is one
// byte per clock with no gaps between buffers. Results wait in a four-entry queue;
// in_tready drops only when that queue plus the results still in flight would fill
// it, so a stalled consumer eventually stalls the input. Write cfg_wr_data only while
// no request is in flight. No clearing pass is needed after reset.
`default_nettype none
module sync_pattern_window_search #(
  parameter int unsigned MAX_BUFFER = spws_pkg::MAX_BUF_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  // in_tdata: data_byte[7:0]
  input  wire logic                          in_tvalid,
  output logic                               in_tready,
  input  wire logic [7:0]                    in_tdata,
  input  wire logic                          in_tlast,
  // out_tdata: payload_index[10:0], best_match_count[16:11], zero pad[23:17]
  output logic                               out_tvalid,
  input  wire logic                          out_tready,
  output logic      [23:0]                   out_tdata,
  // out_tuser: found[0]
  output logic                               out_tuser,
  input  wire logic                          cfg_wr_en,
  input  wire logic [spws_pkg::CONF_W-1:0]   cfg_wr_data
);
  import spws_pkg::*;

  localparam int unsigned POS_W = $clog2(MAX_BUFFER + 1);

  // Input stage: byte position and per-byte control.
  logic              accept;
  logic              adv;
  logic [POS_W-1:0]  pos_inc;
  logic [POS_W-1:0]  pos_after;
  logic [POS_W-1:0]  pos_r, pos_nxt;
  spws_ctl_t         ctl_r, ctl_nxt;
  logic [POS_W-1:0]  start_r;
  logic [CONF_W-1:0] conf_r;

  // Cell chain.
  logic [7:0]          chain_byte [SYNC_LEN];
  logic [SYNC_LEN-1:0] match;

  // Tracker results.
  logic             res_valid;
  logic             res_have;
  logic [CNT_W-1:0] res_cnt;
  logic [POS_W-1:0] res_start;

  // Result formatting and queue.
  spws_res_t         q_wr_data;
  spws_res_t         q_rd_data;
  logic              q_not_empty;
  logic [QCNT_W-1:0] q_fill;
  logic              q_rd;
  logic [QCNT_W:0]   q_claim;
  logic              res_found;

  assign accept    = in_tvalid && in_tready;
  assign adv       = (pos_r < POS_W'(MAX_BUFFER));
  assign pos_inc   = pos_r + 1'b1;
  assign pos_after = adv ? pos_inc : pos_r;

  always_comb begin
    ctl_nxt.valid = accept;
    ctl_nxt.eval  = adv && (pos_inc >= POS_W'(SYNC_LEN));
    ctl_nxt.first = (pos_inc == POS_W'(SYNC_LEN));
    ctl_nxt.last  = in_tlast;
    ctl_nxt.have  = (pos_after >= POS_W'(SYNC_LEN));
    pos_nxt       = pos_r;
    if (accept) begin
      pos_nxt = in_tlast ? '0 : pos_after;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= '0;
      ctl_r  <= '0;
      conf_r <= CONF_W'(CONF_RESET);
    end else begin
      pos_r <= pos_nxt;
      ctl_r <= ctl_nxt;
      if (cfg_wr_en) begin
        conf_r <= cfg_wr_data;
      end
    end
  end

  // Window start travels beside the control; only read when eval is set.
  always_ff @(posedge clk) begin
    if (accept) begin
      start_r <= pos_inc - POS_W'(SYNC_LEN);
    end
  end

  // The newest byte enters the last cell and every cell hands its byte down.
  for (genvar j = 0; j < SYNC_LEN; j++) begin : g_cell
    logic [7:0] feed;
    if (j == SYNC_LEN - 1) begin : g_tail
      assign feed = in_tdata;
    end else begin : g_mid
      assign feed = chain_byte[j+1];
    end
    spws_cell #(
      .PAT(pattern_at(j))
    ) u_cell (
      .clk      (clk),
      .shift_en (accept && adv),
      .byte_in  (feed),
      .byte_out (chain_byte[j]),
      .match_out(match[j])
    );
  end

  spws_best #(
    .POS_W(POS_W)
  ) u_best (
    .clk      (clk),
    .rst_n    (rst_n),
    .match    (match),
    .ctl      (ctl_r),
    .start    (start_r),
    .res_valid(res_valid),
    .res_have (res_have),
    .res_cnt  (res_cnt),
    .res_start(res_start)
  );

  // Threshold test in integer form: count*100 against confidence*32.
  always_comb begin
    res_found = res_have &&
                ((13'(res_cnt) * 13'd100) >= (13'(conf_r) << 5));
    q_wr_data.found   = res_found;
    q_wr_data.payload = res_found ? PAY_W'(res_start + POS_W'(SYNC_LEN)) : '0;
    q_wr_data.cnt     = res_have ? res_cnt : '0;
  end

  assign q_rd = out_tvalid && out_tready;

  spws_outq u_outq (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (res_valid),
    .wr_data  (q_wr_data),
    .rd_en    (q_rd),
    .rd_data  (q_rd_data),
    .not_empty(q_not_empty),
    .fill     (q_fill)
  );

  // Reserve queue room for every closing byte still in the pipeline.
  assign q_claim   = (QCNT_W+1)'(q_fill) + (QCNT_W+1)'(ctl_r.valid && ctl_r.last)
                     + (QCNT_W+1)'(res_valid);
  assign in_tready = (q_claim < (QCNT_W+1)'(QDEPTH));

  assign out_tvalid = q_not_empty;
  assign out_tuser  = q_rd_data.found;
  assign out_tdata  = {7'd0, q_rd_data.cnt, q_rd_data.payload};

`include "sync_pattern_window_search_assert.svh"

  `SPWS_ASSERT_NEVER(a_pos_bound, clk, rst_n, pos_r > POS_W'(MAX_BUFFER))
  `SPWS_ASSERT_NEXT(a_pos_clear, clk, rst_n, accept && in_tlast, pos_r == '0)
  `SPWS_ASSERT_NEVER(a_q_overflow, clk, rst_n, res_valid && !q_rd && (q_fill == QCNT_W'(QDEPTH)))

endmodule
`default_nettype wire
